[sv/lpfd_pkg.sv]
// shared types and constants for the length-prefixed frame decoder
package lpfd_pkg;

  // header is one flags byte and a four-byte big-endian length
  localparam logic [2:0] HDR_BYTES = 3'd5;
  // shift that keeps the low three length bytes when a new byte enters
  localparam int LEN_KEEP = 24;

  localparam logic [31:0] MAX_LEN_RESET = 32'd4194304;

  // result kinds
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_BYTE   = 3'd1;
  localparam logic [2:0] KIND_EMPTY  = 3'd2;
  localparam logic [2:0] KIND_ERROR  = 3'd3;
  localparam logic [2:0] KIND_FINISH = 3'd4;

  // finish verdict
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [7:0] frame_flags;
    logic       last_of_frame;
    logic       status;
  } out_item_t;

endpackage

[sv/lpfd_step.sv]
// frame state registers and the per-byte decode step
module lpfd_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  lpfd_pkg::in_item_t item,
  input  logic [31:0]        max_len,
  output lpfd_pkg::out_item_t result
);
  import lpfd_pkg::*;

  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] pay_cnt_r, pay_cnt_nxt;
  logic        err_r, err_nxt;

  logic [2:0]  hdr_inc;
  logic [31:0] pay_inc;

  assign hdr_inc = hdr_cnt_r + 3'd1;
  assign pay_inc = pay_cnt_r + 32'd1;

  // decode one transaction against the current frame state
  always_comb begin
    hdr_cnt_nxt = hdr_cnt_r;
    flags_nxt   = flags_r;
    len_nxt     = len_r;
    pay_cnt_nxt = pay_cnt_r;
    err_nxt     = err_r;
    result      = '0;
    result.kind = KIND_NONE;

    if (item.end_of_stream) begin
      result.kind   = KIND_FINISH;
      result.status = (err_r || hdr_cnt_r != 3'd0) ? STATUS_INVALID : STATUS_OK;
    end else if (err_r) begin
      result.kind = KIND_NONE;
    end else if (hdr_cnt_r < HDR_BYTES) begin
      // header collection
      if (hdr_cnt_r == 3'd0) begin
        flags_nxt = item.in_byte;
        len_nxt   = '0;
      end else begin
        len_nxt = {len_r[LEN_KEEP-1:0], item.in_byte};
      end
      hdr_cnt_nxt = hdr_inc;
      if (hdr_inc == HDR_BYTES) begin
        if (len_nxt > max_len) begin
          err_nxt            = 1'b1;
          result.kind        = KIND_ERROR;
          result.frame_flags = flags_r;
          result.status      = STATUS_INVALID;
        end else begin
          pay_cnt_nxt = '0;
          if (len_nxt == 32'd0) begin
            hdr_cnt_nxt = 3'd0;
            if (flags_r != 8'd0) begin
              result.kind          = KIND_EMPTY;
              result.frame_flags   = flags_r;
              result.last_of_frame = 1'b1;
            end
          end
        end
      end
    end else begin
      // payload streaming
      result.kind        = KIND_BYTE;
      result.out_byte    = item.in_byte;
      result.frame_flags = flags_r;
      if (pay_inc >= len_r) begin
        result.last_of_frame = 1'b1;
        hdr_cnt_nxt          = 3'd0;
        pay_cnt_nxt          = '0;
      end else begin
        pay_cnt_nxt = pay_inc;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r <= 3'd0;
      err_r     <= 1'b0;
      flags_r   <= 8'd0;
      len_r     <= 32'd0;
      pay_cnt_r <= 32'd0;
    end else if (fire) begin
      hdr_cnt_r <= hdr_cnt_nxt;
      err_r     <= err_nxt;
      flags_r   <= flags_nxt;
      len_r     <= len_nxt;
      pay_cnt_r <= pay_cnt_nxt;
    end
  end

  // header count never passes the header size
  a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r <= HDR_BYTES)
    else $error("header count out of range");

  // the oversize error is sticky
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("sticky error cleared");

  // while payload streams, fewer bytes have gone out than the length
  a_pay_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (hdr_cnt_r == HDR_BYTES && !err_r) |-> (pay_cnt_r < len_r))
    else $error("payload count reached frame length");

  // payload count is zero between frames
  a_pay_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (hdr_cnt_r == 3'd0) |-> (pay_cnt_r == 32'd0))
    else $error("payload count nonzero outside a frame");

endmodule

[sv/lpfd_out_reg.sv]
// result register on the output channel
module lpfd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  lpfd_pkg::out_item_t load_data,
  input  logic                out_stall,
  output logic                out_valid,
  output lpfd_pkg::out_item_t out_data
);
  import lpfd_pkg::*;

  logic      valid_r;
  out_item_t data_r;

  // valid tracks load and downstream take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall) |-> !load)
    else $error("stalled result overwritten");

endmodule

[sv/length_prefixed_frame_decoder.sv]
// top level of the length-prefixed frame decoder
// path: an accepted transaction is held in the input register, decoded, and then held in the result register
// throughput: one byte per cycle while the output is not stalled, set by the combinational decode
//   step between the input register and the result register
// reset: synchronous active-low rst_n clears the frame state and sticky error and
//   loads max_len_r with 4194304
module length_prefixed_frame_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpfd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpfd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);
  import lpfd_pkg::*;

  logic        in_valid_r;
  in_item_t    in_data_r;
  logic [31:0] max_len_r;
  logic        advance;
  logic        fire;
  logic        in_take;
  out_item_t   step_res;

  // the result register frees up when empty or being taken
  assign advance  = !out_valid || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  // input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  lpfd_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (in_data_r),
    .max_len (max_len_r),
    .result  (step_res)
  );

  lpfd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .load_data (step_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a held transaction moves on as soon as the result side frees up
  a_fire_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_valid) |-> fire)
    else $error("held transaction not issued");

  // every issued transaction shows up as a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("issued transaction lost");

  // an accepted transaction is held in the input register next cycle
  a_take_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_valid_r)
    else $error("accepted transaction dropped");

endmodule
